// ===== sv/rmwq_pkg.sv =====
// Package for the recursive mutex with wait queue.
// Holds the shared sizes, codes and word structs; depends on nothing.
package rmwq_pkg;

    // Sizes of the lock and of its wait queue.
    localparam int MAX_TASKS  = 16;
    localparam int COUNT_BITS = 8;
    localparam int ID_W       = 4;
    localparam int ID_SPACE   = 1 << ID_W;
    localparam int DEPTH_W    = 8;
    localparam int STATUS_W   = 3;
    localparam int PTR_W      = $clog2(MAX_TASKS);
    localparam int FILL_W     = $clog2(MAX_TASKS + 1);

    // Request operation codes.
    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 3'd0,
        ST_NESTED     = 3'd1,
        ST_QUEUED     = 3'd2,
        ST_UNNESTED   = 3'd3,
        ST_HANDED     = 3'd4,
        ST_FREED      = 3'd5,
        ST_NOT_HOLDER = 3'd6,
        ST_REFUSED    = 3'd7
    } status_t;

    // One request word.
    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] task_id;
    } req_t;

    // One result word.
    typedef struct packed {
        status_t            status;
        logic               woken_valid;
        logic [ID_W-1:0]    woken_id;
        logic               locked;
        logic [ID_W-1:0]    holder_id;
        logic [DEPTH_W-1:0] depth;
    } result_t;

endpackage

// ===== sv/rmwq_in_stage.sv =====
// Input register for request words of the recursive mutex.
// Depends on rmwq_pkg for the request word type.
module rmwq_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rmwq_pkg::req_t s_req,
    output logic           req_valid,
    input  logic           req_take,
    output rmwq_pkg::req_t req
);
    import rmwq_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    // The register can load whenever it is empty or its word leaves this cycle.
    assign s_ready    = !valid_reg || req_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !req_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

// ===== sv/rmwq_core.sv =====
// Lock state, wait queue and the decision for one request word.
// Depends on rmwq_pkg; the state changes only when commit is high.
module rmwq_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              commit,
    input  rmwq_pkg::req_t    req,
    output rmwq_pkg::result_t res
);
    import rmwq_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
    localparam logic [PTR_W-1:0]      PTR_LAST   = PTR_W'(MAX_TASKS - 1);
    localparam logic [FILL_W-1:0]     FILL_FULL  = FILL_W'(MAX_TASKS);

    logic                  held_reg,  held_next;
    logic [ID_W-1:0]       owner_reg, owner_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [PTR_W-1:0]      head_reg,  head_next;
    logic [PTR_W-1:0]      tail_reg,  tail_next;
    logic [FILL_W-1:0]     fill_reg,  fill_next;
    logic [ID_SPACE-1:0]   mask_reg,  mask_next;
    logic [ID_W-1:0]       fifo_mem [MAX_TASKS];

    logic            push;
    logic            pop;
    logic [ID_W-1:0] head_id;
    status_t         status;

    assign head_id = fifo_mem[head_reg];

    // Decide the outcome of the request against the present lock state.
    always_comb begin
        held_next  = held_reg;
        owner_next = owner_reg;
        count_next = count_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        mask_next  = mask_reg;
        push       = 1'b0;
        pop        = 1'b0;
        status     = ST_REFUSED;
        unique case (req.op)
            OP_ACQUIRE: begin
                priority if (!held_reg) begin
                    held_next  = 1'b1;
                    owner_next = req.task_id;
                    count_next = COUNT_ONE;
                    status     = ST_GRANTED;
                end else if (owner_reg == req.task_id) begin
                    if (count_reg == COUNT_MAX) begin
                        status = ST_REFUSED;
                    end else begin
                        count_next = count_reg + COUNT_ONE;
                        status     = ST_NESTED;
                    end
                end else if (mask_reg[req.task_id] || fill_reg >= FILL_FULL) begin
                    status = ST_REFUSED;
                end else begin
                    push                 = 1'b1;
                    tail_next            = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                    fill_next            = fill_reg + 1'b1;
                    mask_next[req.task_id] = 1'b1;
                    status               = ST_QUEUED;
                end
            end
            OP_RELEASE: begin
                priority if (!held_reg || owner_reg != req.task_id) begin
                    status = ST_NOT_HOLDER;
                end else if (count_reg > COUNT_ONE) begin
                    count_next = count_reg - COUNT_ONE;
                    status     = ST_UNNESTED;
                end else if (fill_reg != '0) begin
                    // The oldest waiter takes the lock in the same step.
                    pop                = 1'b1;
                    head_next          = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                    fill_next          = fill_reg - 1'b1;
                    mask_next[head_id] = 1'b0;
                    owner_next         = head_id;
                    count_next         = COUNT_ONE;
                    status             = ST_HANDED;
                end else begin
                    held_next  = 1'b0;
                    owner_next = '0;
                    count_next = '0;
                    status     = ST_FREED;
                end
            end
            default: begin
                status = ST_REFUSED;
            end
        endcase
    end

    // Result word reports the state after this request.
    always_comb begin
        res.status      = status;
        res.woken_valid = pop;
        res.woken_id    = pop ? head_id : '0;
        res.locked      = held_next;
        res.holder_id   = held_next ? owner_next : '0;
        res.depth       = DEPTH_W'(count_next);
    end

    // Lock and queue control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 1'b0;
            owner_reg <= '0;
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            mask_reg  <= '0;
        end else if (commit) begin
            held_reg  <= held_next;
            owner_reg <= owner_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            mask_reg  <= mask_next;
        end
    end

    // Waiter ids; an entry is only read after it has been written.
    always_ff @(posedge aclk) begin
        if (commit && push) begin
            fifo_mem[tail_reg] <= req.task_id;
        end
    end

    // The queue count always matches the number of waiting tasks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(mask_reg) == int'(fill_reg))
        else $error("wait mask and queue count disagree");

    // The queue never holds more than its capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("wait queue count beyond capacity");

    // A free lock has no owner and no count; a held lock has a count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg ? (count_reg != '0) : (count_reg == '0 && owner_reg == '0))
        else $error("lock count inconsistent with lock state");

    // The holder is never also waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !held_reg || !mask_reg[owner_reg])
        else $error("lock holder found in wait queue");

    // A handover leaves the woken task as holder with a count of one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && pop) |=> (held_reg && count_reg == COUNT_ONE
                             && owner_reg == $past(head_id)))
        else $error("handover did not install the woken waiter");

endmodule

// ===== sv/rmwq_out_stage.sv =====
// Output register for result words of the recursive mutex.
// Depends on rmwq_pkg for the result word type.
module rmwq_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    output logic              res_take,
    input  rmwq_pkg::result_t res,
    output logic              m_valid,
    input  logic              m_ready,
    output rmwq_pkg::result_t m_res
);
    import rmwq_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A new word loads when the register is empty or its word is taken now.
    assign res_take   = res_valid && (!valid_reg || m_ready);
    assign valid_next = res_take || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== sv/recursive_mutex_with_wait_queue_unit.sv =====
// Top level of the recursive mutex with a FIFO of waiting tasks.
// Depends on rmwq_pkg, rmwq_in_stage, rmwq_core and rmwq_out_stage.
//
// Each request word (acquire or release from one task) gives exactly one result
// word. The unit takes one request per clock cycle unless the result port stalls.
// Each accepted request is held in the input register while the lock decision
// and the wait queue push or pop settle in a single pass into the output
// register. The lock state updates as each result is registered, so back-to-back
// requests see each other's effect. Only a stalled result port slows the input
// side. No clearing pass is needed after reset.
module recursive_mutex_with_wait_queue_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [rmwq_pkg::ID_W-1:0]       s_task_id,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rmwq_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_woken_valid,
    output logic [rmwq_pkg::ID_W-1:0]       m_woken_id,
    output logic                            m_locked,
    output logic [rmwq_pkg::ID_W-1:0]       m_holder_id,
    output logic [rmwq_pkg::DEPTH_W-1:0]    m_depth
);
    import rmwq_pkg::*;

    req_t    s_req;
    req_t    req;
    logic    req_valid;
    logic    res_take;
    result_t res;
    result_t m_res;

    assign s_req.op      = op_t'(s_op);
    assign s_req.task_id = s_task_id;

    // Request input register.
    rmwq_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .req_valid (req_valid),
        .req_take  (res_take),
        .req       (req)
    );

    // Lock decision and state; commits when the result register loads.
    rmwq_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (res_take),
        .req     (req),
        .res     (res)
    );

    // Result output register.
    rmwq_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (req_valid),
        .res_take  (res_take),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_status      = m_res.status;
    assign m_woken_valid = m_res.woken_valid;
    assign m_woken_id    = m_res.woken_id;
    assign m_locked      = m_res.locked;
    assign m_holder_id   = m_res.holder_id;
    assign m_depth       = m_res.depth;

endmodule

// ===== tb/sv/tb_recursive_mutex_with_wait_queue_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for recursive_mutex_with_wait_queue_unit.
// Depends on rmwq_pkg and the unit itself; it predicts every result word and
// compares it field by field.
module tb_recursive_mutex_with_wait_queue_unit;

    import rmwq_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic                 s_op          = 1'b0;
    logic [ID_W-1:0]      s_task_id     = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic                 m_woken_valid;
    logic [ID_W-1:0]      m_woken_id;
    logic                 m_locked;
    logic [ID_W-1:0]      m_holder_id;
    logic [DEPTH_W-1:0]   m_depth;

    // Predicted lock state, kept in step with every accepted request word.
    logic                  mx_locked;
    logic [ID_W-1:0]       mx_owner;
    logic [COUNT_BITS-1:0] mx_count;
    logic [ID_W-1:0]       waiter_ring [MAX_TASKS];
    int                    ring_rd;
    int                    ring_wr;
    int                    ring_count;
    logic [ID_SPACE-1:0]   is_waiting;

    // Results still owed by the unit, oldest first.
    result_t lock_results[$];

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int unsigned errors        = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned status_seen [8];

    recursive_mutex_with_wait_queue_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_task_id     (s_task_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_woken_valid (m_woken_valid),
        .m_woken_id    (m_woken_id),
        .m_locked      (m_locked),
        .m_holder_id   (m_holder_id),
        .m_depth       (m_depth)
    );

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The result port stalls at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void reset_lock_model();
        mx_locked  = 1'b0;
        mx_owner   = '0;
        mx_count   = '0;
        ring_rd    = 0;
        ring_wr    = 0;
        ring_count = 0;
        is_waiting = '0;
        for (int i = 0; i < MAX_TASKS; i++) waiter_ring[i] = '0;
    endfunction

    // Applies one request to the predicted state and returns the result word.
    function automatic result_t predict_lock_result(op_t op, logic [ID_W-1:0] id);
        result_t         r;
        logic [ID_W-1:0] w;
        r = '0;
        if (op == OP_ACQUIRE) begin
            if (!mx_locked) begin
                mx_locked = 1'b1;
                mx_owner  = id;
                mx_count  = COUNT_BITS'(1);
                r.status  = ST_GRANTED;
            end else if (mx_owner == id) begin
                // The count saturates rather than wrapping.
                if (mx_count == COUNT_MAX) begin
                    r.status = ST_REFUSED;
                end else begin
                    mx_count = mx_count + 1'b1;
                    r.status = ST_NESTED;
                end
            end else if (is_waiting[id] || ring_count >= MAX_TASKS) begin
                r.status = ST_REFUSED;
            end else begin
                waiter_ring[ring_wr] = id;
                ring_wr = (ring_wr == MAX_TASKS - 1) ? 0 : ring_wr + 1;
                ring_count++;
                is_waiting[id] = 1'b1;
                r.status = ST_QUEUED;
            end
        end else begin
            if (!mx_locked || mx_owner != id) begin
                r.status = ST_NOT_HOLDER;
            end else if (mx_count > 1) begin
                mx_count = mx_count - 1'b1;
                r.status = ST_UNNESTED;
            end else if (ring_count > 0) begin
                // The oldest waiter takes the lock in the same step.
                w = waiter_ring[ring_rd];
                ring_rd = (ring_rd == MAX_TASKS - 1) ? 0 : ring_rd + 1;
                ring_count--;
                is_waiting[w] = 1'b0;
                mx_owner      = w;
                mx_count      = COUNT_BITS'(1);
                r.woken_valid = 1'b1;
                r.woken_id    = w;
                r.status      = ST_HANDED;
            end else begin
                mx_locked = 1'b0;
                mx_owner  = '0;
                mx_count  = '0;
                r.status  = ST_FREED;
            end
        end
        r.locked    = mx_locked;
        r.holder_id = mx_locked ? mx_owner : '0;
        r.depth     = DEPTH_W'(mx_count);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
        errors++;
        if (errors <= 40)
            $display("error: result %0d, %s is %0d, expected %0d",
                     results_seen, field, got, want);
    endtask

    // Sends one request word, idling first at the rate of the current phase.
    task automatic send_request(op_t op, logic [ID_W-1:0] id);
        result_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_task_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = predict_lock_result(op, id);
        lock_results.push_back(want);
        status_seen[want.status]++;
        requests_sent++;
    endtask

    // Withdraws the last word and waits until every owed result has arrived or its wait limit runs out.
    task automatic wait_results_drained();
        int cycles;
        cycles = 0;
        s_valid <= 1'b0;
        while (lock_results.size() != 0 && cycles < 20000) begin
            @(posedge aclk);
            cycles++;
        end
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Each result word is checked against the oldest expectation.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (lock_results.size() == 0) begin
                report_mismatch("status (nothing expected)", 8'(m_status), 8'd0);
            end else begin
                want = lock_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 8'(m_status), 8'(want.status));
                if (m_woken_valid !== want.woken_valid)
                    report_mismatch("woken_valid", 8'(m_woken_valid),
                                    8'(want.woken_valid));
                if (m_woken_id !== want.woken_id)
                    report_mismatch("woken_id", 8'(m_woken_id), 8'(want.woken_id));
                if (m_locked !== want.locked)
                    report_mismatch("locked", 8'(m_locked), 8'(want.locked));
                if (m_holder_id !== want.holder_id)
                    report_mismatch("holder_id", 8'(m_holder_id), 8'(want.holder_id));
                if (m_depth !== want.depth)
                    report_mismatch("depth", m_depth, want.depth);
            end
        end
    end

    // Hand-picked walk through every status, starting from a free lock.
    task automatic test_directed_cases();
        send_request(OP_RELEASE, 4'd0);
        send_request(OP_ACQUIRE, 4'd15);
        send_request(OP_ACQUIRE, 4'd15);
        send_request(OP_ACQUIRE, 4'd0);
        send_request(OP_ACQUIRE, 4'd0);
        send_request(OP_ACQUIRE, 4'd5);
        send_request(OP_ACQUIRE, 4'd10);
        send_request(OP_RELEASE, 4'd0);
        send_request(OP_RELEASE, 4'd3);
        send_request(OP_RELEASE, 4'd15);
        send_request(OP_RELEASE, 4'd15);
        send_request(OP_ACQUIRE, 4'd15);
        send_request(OP_ACQUIRE, 4'd0);
        send_request(OP_RELEASE, 4'd0);
        send_request(OP_RELEASE, 4'd0);
        send_request(OP_RELEASE, 4'd5);
        send_request(OP_RELEASE, 4'd10);
        send_request(OP_RELEASE, 4'd15);
        send_request(OP_RELEASE, 4'd15);
        send_request(OP_ACQUIRE, 4'd10);
        send_request(OP_RELEASE, 4'd10);
        send_request(OP_ACQUIRE, 4'd0);
        send_request(OP_RELEASE, 4'd0);
    endtask

    // The holder nests up to the largest count, then past it twice, and unwinds.
    task automatic test_recursion_overflow();
        logic [ID_W-1:0] holder;
        logic [ID_W-1:0] other;
        holder = ID_W'($urandom_range(ID_SPACE - 1));
        other  = holder ^ ID_W'($urandom_range(1, ID_SPACE - 1));
        for (int i = 0; i <= int'(COUNT_MAX) + 1; i++) send_request(OP_ACQUIRE, holder);
        send_request(OP_ACQUIRE, other);
        for (int i = 0; i < int'(COUNT_MAX); i++) send_request(OP_RELEASE, holder);
        send_request(OP_RELEASE, other);
    endtask

    // Every other task queues behind one holder, then the lock passes down the line.
    task automatic test_full_wait_queue();
        logic [ID_W-1:0] order [ID_SPACE - 1];
        logic [ID_W-1:0] holder;
        logic [ID_W-1:0] tmp;
        int              n;
        int              j;
        holder = ID_W'($urandom_range(ID_SPACE - 1));
        n = 0;
        for (int id = 0; id < ID_SPACE; id++)
            if (ID_W'(id) != holder) begin
                order[n] = ID_W'(id);
                n++;
            end
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        send_request(OP_ACQUIRE, holder);
        for (int i = 0; i < n; i++) send_request(OP_ACQUIRE, order[i]);
        for (int i = 0; i < n; i++) send_request(OP_ACQUIRE, order[i]);
        send_request(OP_ACQUIRE, holder);
        send_request(OP_RELEASE, order[0]);
        send_request(OP_RELEASE, holder);
        send_request(OP_RELEASE, holder);
        for (int i = 0; i < n; i++) send_request(OP_RELEASE, order[i]);
    endtask

    // Mostly plausible traffic: the holder nests and releases while others
    // queue, with some requests from arbitrary tasks mixed in.
    task automatic test_random_traffic(int count);
        int              roll;
        op_t             op;
        logic [ID_W-1:0] id;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 15) begin
                op = $urandom_range(1) ? OP_RELEASE : OP_ACQUIRE;
                id = ID_W'($urandom_range(ID_SPACE - 1));
            end else if (mx_locked && roll < 65) begin
                op = ($urandom_range(99) < 65) ? OP_RELEASE : OP_ACQUIRE;
                id = mx_owner;
            end else begin
                op = OP_ACQUIRE;
                id = ID_W'($urandom_range(ID_SPACE - 1));
            end
            send_request(op, id);
        end
    endtask

    // Test sequence.
    initial begin
        reset_lock_model();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(0, 0);
        test_directed_cases();
        wait_results_drained();

        set_idling(9, 9);
        test_recursion_overflow();
        wait_results_drained();

        set_idling(0, 86);
        test_full_wait_queue();
        wait_results_drained();

        set_idling(0, 0);
        test_random_traffic(50);
        set_idling(86, 0);
        test_random_traffic(50);
        set_idling(0, 86);
        test_random_traffic(50);
        set_idling(9, 9);
        test_random_traffic(50);

        wait_results_drained();
        repeat (8) @(posedge aclk);
        while (lock_results.size() != 0) begin
            void'(lock_results.pop_front());
            report_mismatch("status (never arrived)", 8'd0, 8'd0);
        end

        $display("Sent %0d requests and checked %0d results.", requests_sent, results_seen);
        $display("Statuses: granted %0d, nested %0d, queued %0d, unnested %0d, handed %0d, %s",
                 status_seen[ST_GRANTED], status_seen[ST_NESTED], status_seen[ST_QUEUED],
                 status_seen[ST_UNNESTED], status_seen[ST_HANDED],
                 $sformatf("freed %0d, not holder %0d, refused %0d",
                           status_seen[ST_FREED], status_seen[ST_NOT_HOLDER],
                           status_seen[ST_REFUSED]));
        if (errors == 0) begin
            $display("recursive_mutex_with_wait_queue_unit: match");
        end else begin
            $display("recursive_mutex_with_wait_queue_unit: mismatch");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2000000;
        $display("recursive_mutex_with_wait_queue_unit: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rmwq_pkg.sv
sv/rmwq_in_stage.sv
sv/rmwq_core.sv
sv/rmwq_out_stage.sv
sv/recursive_mutex_with_wait_queue_unit.sv
tb/sv/tb_recursive_mutex_with_wait_queue_unit.sv
